// File: hw/rtl/qsort_pkg.sv
`default_nettype none

package qsort_pkg;

  localparam int DATA_W = 32;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic push_init;
    logic pop;
    logic take_range;
    logic take_pivot;
    logic read_i;
    logic capture_va;
    logic swap_a;
    logic swap_b;
    logic step_both;
    logic step_j;
    logic fin_a;
    logic fin_b;
    logic push_right;
    logic push_left;
    logic read_k;
    logic show;
    logic next_k;
    logic clear_set;
  } cmd_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic le;
    logic i_eq_j;
    logic j_at_hi;
    logic stack_empty;
    logic right_ok;
    logic left_ok;
    logic k_last;
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/qsort_dp.sv
`default_nettype none

module qsort_dp #(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire                                clk,
  input  wire                                rst,
  input  qsort_pkg::cmd_t                    cmd,
  output qsort_pkg::status_t                 status,
  input  wire signed [qsort_pkg::DATA_W-1:0] value,
  output logic signed [qsort_pkg::DATA_W-1:0] sorted_value,
  output logic                               end_of_set,
  output logic                               dropped
);

  localparam int IW = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int SW = 2 * IW;

  logic [qsort_pkg::DATA_W-1:0] store [MAX_ELEMENTS];
  logic [SW-1:0]                stack [MAX_ELEMENTS];

  logic [qsort_pkg::DATA_W-1:0] rdata;
  logic [SW-1:0]                srdata;
  logic [CW-1:0]                count;
  logic [CW-1:0]                sp;
  logic                         overflow_seen;
  logic [IW-1:0]                lo;
  logic [IW-1:0]                hi;
  logic [IW-1:0]                i;
  logic [IW-1:0]                j;
  logic [IW-1:0]                k;
  logic [qsort_pkg::DATA_W-1:0] pivot;
  logic [qsort_pkg::DATA_W-1:0] va;
  logic [qsort_pkg::DATA_W-1:0] vb;

  logic [CW-1:0]                sp_dec;
  logic                         has_room;
  logic [IW-1:0]                raddr;
  logic                         we;
  logic [IW-1:0]                waddr;
  logic [qsort_pkg::DATA_W-1:0] wdata;
  logic                         swe;
  logic [SW-1:0]                swdata;
  logic [IW:0]                  i_ext;
  logic [IW:0]                  hi_ext;
  logic [IW:0]                  lo_ext;

  assign sp_dec   = sp - CW'(1);
  assign has_room = (count < CW'(MAX_ELEMENTS));
  assign i_ext    = {1'b0, i};
  assign hi_ext   = {1'b0, hi};
  assign lo_ext   = {1'b0, lo};

  always_comb begin
    if (cmd.take_range) begin
      raddr = srdata[IW-1:0];
    end else if (cmd.read_i) begin
      raddr = i;
    end else if (cmd.read_k) begin
      raddr = k;
    end else begin
      raddr = j;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = j;
    wdata = vb;
    if (cmd.load) begin
      we    = has_room;
      waddr = count[IW-1:0];
      wdata = value;
    end else if (cmd.swap_a) begin
      we    = 1'b1;
      waddr = i;
      wdata = va;
    end else if (cmd.swap_b) begin
      we    = 1'b1;
      waddr = j;
      wdata = vb;
    end else if (cmd.fin_a) begin
      we    = 1'b1;
      waddr = hi;
      wdata = rdata;
    end else if (cmd.fin_b) begin
      we    = 1'b1;
      waddr = i;
      wdata = pivot;
    end
  end

  always_comb begin
    swe    = 1'b0;
    swdata = {i + IW'(1), hi};
    if (cmd.push_init) begin
      swe    = (count > CW'(1));
      swdata = {IW'(0), IW'(count - CW'(1))};
    end else if (cmd.push_right) begin
      swe    = 1'b1;
      swdata = {i + IW'(1), hi};
    end else if (cmd.push_left) begin
      swe    = 1'b1;
      swdata = {lo, i - IW'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

  always_ff @(posedge clk) begin
    if (swe) begin
      stack[sp[IW-1:0]] <= swdata;
    end
    srdata <= stack[sp_dec[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      sp            <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (has_room) begin
          count <= count + CW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (swe) begin
        sp <= sp + CW'(1);
      end else if (cmd.pop) begin
        sp <= sp_dec;
      end
      if (cmd.clear_set) begin
        count         <= '0;
        sp            <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_range) begin
      lo <= srdata[SW-1:IW];
      hi <= srdata[IW-1:0];
    end
    if (cmd.take_pivot) begin
      pivot <= rdata;
      i     <= lo;
      j     <= lo;
    end
    if (cmd.capture_va) begin
      va <= rdata;
    end
    if (cmd.swap_a) begin
      vb <= rdata;
    end
    if (cmd.step_both) begin
      i <= i + IW'(1);
      j <= j + IW'(1);
    end
    if (cmd.step_j) begin
      j <= j + IW'(1);
    end
    if (cmd.push_init) begin
      k <= '0;
    end
    if (cmd.next_k) begin
      k <= k + IW'(1);
    end
    if (cmd.show) begin
      sorted_value <= rdata;
      end_of_set   <= status.k_last;
      dropped      <= overflow_seen;
    end
  end

  assign status.le          = ($signed(rdata) <= $signed(pivot));
  assign status.i_eq_j      = (i == j);
  assign status.j_at_hi     = (j == hi);
  assign status.stack_empty = (sp == '0);
  assign status.right_ok    = ((i_ext + (IW+1)'(1)) < hi_ext);
  assign status.left_ok     = (i_ext >= (lo_ext + (IW+1)'(2)));
  assign status.k_last      = ((CW'(k) + CW'(1)) == count);

  // Pushed ranges are disjoint and hold two elements or more.
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CW'(MAX_ELEMENTS / 2))
    else $error("range stack deeper than half the capacity");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !has_room) |=> overflow_seen)
    else $error("item at full store not flagged as dropped");

endmodule

`default_nettype wire

// File: hw/rtl/qsort_ctrl.sv
`default_nettype none

module qsort_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_stall,
  input  wire                 is_last,
  output logic                result_valid,
  input  wire                 result_stall,
  output qsort_pkg::cmd_t     cmd,
  input  qsort_pkg::status_t  status
);

  typedef enum logic [4:0] {
    S_LOAD,
    S_INIT,
    S_POP,
    S_RANGE,
    S_PIVOT,
    S_SCAN,
    S_CMP,
    S_SWAP_A,
    S_SWAP_B,
    S_FIN_RD,
    S_FIN_A,
    S_FIN_B,
    S_PUSH_R,
    S_PUSH_L,
    S_OUT_RD,
    S_OUT_WT,
    S_OUT_HOLD
  } state_t;

  state_t state;
  logic   item_take;
  logic   result_take;

  assign item_take   = (state == S_LOAD) && item_valid && !item_stall;
  assign result_take = (state == S_OUT_HOLD) && result_valid && !result_stall;

  // The scan state needs no command: the store address defaults to j.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_LOAD:   cmd.load = item_take;
      S_INIT:   cmd.push_init = 1'b1;
      S_POP:    cmd.pop = !status.stack_empty;
      S_RANGE:  cmd.take_range = 1'b1;
      S_PIVOT:  cmd.take_pivot = 1'b1;
      S_CMP: begin
        cmd.capture_va = 1'b1;
        if (status.le) begin
          cmd.step_both = status.i_eq_j;
          cmd.read_i    = !status.i_eq_j;
        end else begin
          cmd.step_j = 1'b1;
        end
      end
      S_SWAP_A: cmd.swap_a = 1'b1;
      S_SWAP_B: begin
        cmd.swap_b    = 1'b1;
        cmd.step_both = 1'b1;
      end
      S_FIN_RD: cmd.read_i = 1'b1;
      S_FIN_A:  cmd.fin_a = 1'b1;
      S_FIN_B:  cmd.fin_b = 1'b1;
      S_PUSH_R: cmd.push_right = status.right_ok;
      S_PUSH_L: cmd.push_left = status.left_ok;
      S_OUT_RD: cmd.read_k = 1'b1;
      S_OUT_WT: cmd.show = 1'b1;
      S_OUT_HOLD: begin
        cmd.next_k    = result_take && !status.k_last;
        cmd.clear_set = result_take && status.k_last;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      item_stall   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (item_take && is_last) begin
            state      <= S_INIT;
            item_stall <= 1'b1;
          end
        end
        S_INIT:   state <= S_POP;
        S_POP:    state <= status.stack_empty ? S_OUT_RD : S_RANGE;
        S_RANGE:  state <= S_PIVOT;
        S_PIVOT:  state <= S_SCAN;
        S_SCAN:   state <= status.j_at_hi ? S_FIN_RD : S_CMP;
        S_CMP: begin
          if (status.le && !status.i_eq_j) begin
            state <= S_SWAP_A;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SWAP_A: state <= S_SWAP_B;
        S_SWAP_B: state <= S_SCAN;
        S_FIN_RD: state <= S_FIN_A;
        S_FIN_A:  state <= S_FIN_B;
        S_FIN_B:  state <= S_PUSH_R;
        S_PUSH_R: state <= S_PUSH_L;
        S_PUSH_L: state <= S_POP;
        S_OUT_RD: state <= S_OUT_WT;
        S_OUT_WT: begin
          state        <= S_OUT_HOLD;
          result_valid <= 1'b1;
        end
        S_OUT_HOLD: begin
          if (result_take) begin
            result_valid <= 1'b0;
            if (status.k_last) begin
              state      <= S_LOAD;
              item_stall <= 1'b0;
            end else begin
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("item taken while a result is shown");

  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (result_take && status.k_last) |=> !item_stall)
    else $error("block did not reopen after the last result");

  a_sort_start: assert property (@(posedge clk) disable iff (rst)
    (item_take && is_last) |=> (item_stall && cmd.push_init))
    else $error("closing item did not start the sort");

endmodule

`default_nettype wire

// File: hw/rtl/quicksort_lomuto_last_pivot_top.sv
`default_nettype none

// Channel   Handshake                   Payload
// item      item_valid / item_stall     value, is_last
// result    result_valid / result_stall sorted_value, end_of_set, dropped
//
// Loading takes one item per cycle; the item marked is_last starts the sort.
// Each range is partitioned around its last element as pivot; its parts
// of two or more elements are pushed, all through the one element store.
// Each result is read from the store and held until the result channel takes it.
// No item is taken from the closing item until the last result is taken.
// Reset is synchronous and leaves the block empty and ready; no clearing pass.

module quicksort_lomuto_last_pivot_top #(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 item_valid,
  output logic                                item_stall,
  input  wire signed [qsort_pkg::DATA_W-1:0]  value,
  input  wire                                 is_last,
  output logic                                result_valid,
  input  wire                                 result_stall,
  output logic signed [qsort_pkg::DATA_W-1:0] sorted_value,
  output logic                                end_of_set,
  output logic                                dropped
);

  qsort_pkg::cmd_t    cmd;
  qsort_pkg::status_t status;

  qsort_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  qsort_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .sorted_value (sorted_value),
    .end_of_set   (end_of_set),
    .dropped      (dropped)
  );

endmodule

`default_nettype wire
